[src/dbc_pkg.sv]
package dbc_pkg;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_IDLE  = 4'd0;
    localparam step_t STEP_SCALE = 4'd6;
    localparam step_t STEP_LAST  = 4'd8;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_BIT_DEPTH   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HOLD_PERIOD = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_JITTER      = 2'd2;

    localparam logic [4:0]  BIT_DEPTH_RST = 5'd8;
    localparam logic [15:0] HOLD_RST      = 16'd256;
    localparam logic [15:0] JITTER_RST    = 16'd0;
    localparam logic [15:0] HOLD_MIN      = 16'd256;

    localparam logic [31:0] LCG_MUL    = 32'd1664525;
    localparam logic [31:0] LCG_ADD    = 32'd1013904223;
    localparam logic [31:0] LCG_A_SEED = 32'd12764;
    localparam logic [31:0] LCG_B_SEED = 32'd209375;

    localparam int SILENCE_LIMIT_DEF = 512;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_LCG_A,
        OP_JITTER,
        OP_CAPTURE,
        OP_LCG_B,
        OP_SCALE,
        OP_ROUND,
        OP_OUTPUT
    } op_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_IN,
        COND_SILENT,
        COND_OUT,
        COND_JUMP
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ucode_t;

    typedef struct packed {
        logic silent;
        logic out_free;
    } status_t;

    function automatic ucode_t ucode_rom(step_t s);
        ucode_t w;
        unique case (s)
            4'd0:    w = '{OP_ACCEPT,  COND_IN,     STEP_IDLE};
            4'd1:    w = '{OP_LCG_A,   COND_NEXT,   STEP_IDLE};
            4'd2:    w = '{OP_JITTER,  COND_NEXT,   STEP_IDLE};
            4'd3:    w = '{OP_CAPTURE, COND_SILENT, STEP_SCALE};
            4'd4:    w = '{OP_LCG_A,   COND_NEXT,   STEP_IDLE};
            4'd5:    w = '{OP_LCG_B,   COND_NEXT,   STEP_IDLE};
            4'd6:    w = '{OP_SCALE,   COND_NEXT,   STEP_IDLE};
            4'd7:    w = '{OP_ROUND,   COND_NEXT,   STEP_IDLE};
            4'd8:    w = '{OP_OUTPUT,  COND_OUT,    STEP_IDLE};
            default: w = '{OP_NONE,    COND_JUMP,   STEP_IDLE};
        endcase
        return w;
    endfunction

    // Rounded reciprocal of 2^bd - 1, scaled by 2^32.
    function automatic logic [32:0] recip_rom(logic [4:0] bd);
        logic [32:0] r;
        unique case (bd)
            5'd1:    r = 33'h1_0000_0000;
            5'd2:    r = 33'h0_5555_5555;
            5'd3:    r = 33'h0_2492_4925;
            5'd4:    r = 33'h0_1111_1111;
            5'd5:    r = 33'h0_0842_1084;
            5'd6:    r = 33'h0_0410_4104;
            5'd7:    r = 33'h0_0204_0810;
            5'd8:    r = 33'h0_0101_0101;
            5'd9:    r = 33'h0_0080_4020;
            5'd10:   r = 33'h0_0040_1004;
            5'd11:   r = 33'h0_0020_0401;
            5'd12:   r = 33'h0_0010_0100;
            5'd13:   r = 33'h0_0008_0040;
            5'd14:   r = 33'h0_0004_0010;
            5'd15:   r = 33'h0_0002_0004;
            default: r = 33'h0_0001_0001;
        endcase
        return r;
    endfunction

endpackage

[src/dbc_sequencer.sv]
module dbc_sequencer
    import dbc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  status_t status,
    output ucode_t  word
);

    step_t step_reg;
    step_t step_next;

    assign word = ucode_rom(step_reg);

    always_comb
    begin
        unique case (word.cond)
            COND_NEXT:   step_next = step_reg + 4'd1;
            COND_IN:     step_next = in_valid ? step_reg + 4'd1 : step_reg;
            COND_SILENT: step_next = status.silent ? word.target : step_reg + 4'd1;
            COND_OUT:    step_next = status.out_free ? word.target : step_reg;
            COND_JUMP:   step_next = word.target;
            default:     step_next = STEP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_LAST)
        else $error("Step counter left the program.");

    a_accept_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && word.op == OP_ACCEPT) |=> (step_reg == STEP_IDLE + 4'd1))
        else $error("Accepted transfer did not start the program.");

    a_output_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (word.op == OP_OUTPUT && !status.out_free) |=> (step_reg == STEP_LAST))
        else $error("Program left the output step while the slot was full.");

endmodule

[src/dbc_datapath.sv]
module dbc_datapath
    import dbc_pkg::*;
#(
    parameter int SILENCE_LIMIT = SILENCE_LIMIT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ucode_t                word,
    output status_t               status,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata,
    output logic                  m_tuser
);

    localparam int SIL_W = $clog2(SILENCE_LIMIT + 1);
    localparam logic [SIL_W-1:0] SIL_MAX = SIL_W'(SILENCE_LIMIT);

    logic [4:0]  bit_depth_reg;
    logic [15:0] hold_period_reg;
    logic [15:0] jitter_reg;

    logic [31:0]       lcg_a_reg;
    logic [31:0]       lcg_b_reg;
    logic [SIL_W-1:0]  silence_reg;
    logic signed [15:0] held_reg;
    logic [15:0]       phase_reg;

    logic signed [15:0] sample_reg;
    logic signed [16:0] joff_reg;
    logic signed [33:0] dither_reg;
    logic signed [32:0] prod_reg;
    logic signed [17:0] code_reg;
    logic               captured_reg;

    logic signed [15:0] crushed_reg;
    logic signed [17:0] level_code_reg;
    logic               flag_reg;
    logic               out_valid_reg;

    logic [4:0]  bd;
    logic [16:0] levels;
    logic [15:0] hp;
    logic [32:0] recip;

    logic signed [33:0] mul_a;
    logic signed [21:0] mul_b;
    logic signed [55:0] mul_p;
    logic [31:0]        lcg_new;

    logic signed [25:0] cmp_lhs;
    logic signed [25:0] cmp_rhs;
    logic               capture;
    logic signed [15:0] held_next;
    logic [SIL_W-1:0]   silence_next;

    logic signed [51:0] acc;
    logic signed [56:0] ysum;
    logic signed [39:0] y;
    logic signed [15:0] y_sat;

    logic in_xfer;
    logic out_free;

    assign s_tready = (word.op == OP_ACCEPT);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, level_code_reg, crushed_reg};
    assign m_tuser  = flag_reg;

    always_comb
    begin
        priority if (bit_depth_reg == 5'd0)
            bd = 5'd1;
        else if (bit_depth_reg > 5'd16)
            bd = 5'd16;
        else
            bd = bit_depth_reg;
    end

    assign levels = (17'd1 << bd) - 17'd1;
    assign hp     = (hold_period_reg < HOLD_MIN) ? HOLD_MIN : hold_period_reg;
    assign recip  = recip_rom(bd);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (word.op)
            OP_LCG_A:
            begin
                mul_a = {2'b0, lcg_a_reg};
                mul_b = {1'b0, LCG_MUL[20:0]};
            end
            OP_LCG_B:
            begin
                mul_a = {2'b0, lcg_b_reg};
                mul_b = {1'b0, LCG_MUL[20:0]};
            end
            OP_JITTER:
            begin
                mul_a = $signed({2'b0, lcg_a_reg}) - 34'sh0_8000_0000;
                mul_b = {6'b0, jitter_reg};
            end
            OP_SCALE:
            begin
                mul_a = {17'b0, levels};
                mul_b = {{6{held_reg[15]}}, held_reg};
            end
            OP_OUTPUT:
            begin
                mul_a = {1'b0, recip};
                mul_b = {{4{code_reg[17]}}, code_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign lcg_new = mul_p[31:0] + LCG_ADD;

    assign cmp_lhs   = $signed({2'b0, phase_reg, 8'b0});
    assign cmp_rhs   = $signed({10'b0, hp}) + {{9{joff_reg[16]}}, joff_reg};
    assign capture   = (cmp_lhs >= cmp_rhs);
    assign held_next = capture ? sample_reg : held_reg;

    always_comb
    begin
        if (held_next == 16'sd0)
            silence_next = (silence_reg < SIL_MAX) ? silence_reg + 1'b1 : silence_reg;
        else
            silence_next = '0;
    end

    assign status.silent   = (silence_next >= SIL_MAX);
    assign status.out_free = out_free;

    assign acc = {{2{prod_reg[32]}}, prod_reg, 17'b0}
               + {{18{dither_reg[33]}}, dither_reg}
               + 52'sh0_0000_8000_0000;

    assign ysum = {mul_p[55], mul_p} + 57'sh0_0001_0000;
    assign y    = ysum[56:17];

    always_comb
    begin
        priority if (y > 40'sd32767)
            y_sat = 16'sh7FFF;
        else if (y < -40'sd32768)
            y_sat = 16'sh8000;
        else
            y_sat = y[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_depth_reg   <= BIT_DEPTH_RST;
            hold_period_reg <= HOLD_RST;
            jitter_reg      <= JITTER_RST;
            lcg_a_reg       <= LCG_A_SEED;
            lcg_b_reg       <= LCG_B_SEED;
            silence_reg     <= '0;
            held_reg        <= '0;
            phase_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_BIT_DEPTH:   bit_depth_reg   <= cfg_wdata[4:0];
                    REG_HOLD_PERIOD: hold_period_reg <= cfg_wdata;
                    REG_JITTER:      jitter_reg      <= cfg_wdata;
                    default:         ;
                endcase
            end

            if (in_xfer && phase_reg != 16'hFFFF)
                phase_reg <= phase_reg + 16'd1;

            if (word.op == OP_LCG_A)
                lcg_a_reg <= lcg_new;
            if (word.op == OP_LCG_B)
                lcg_b_reg <= lcg_new;

            if (word.op == OP_CAPTURE)
            begin
                held_reg    <= held_next;
                silence_reg <= silence_next;
                if (capture)
                    phase_reg <= '0;
            end

            if (word.op == OP_OUTPUT && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            sample_reg <= s_tdata;
        if (word.op == OP_JITTER)
            joff_reg <= mul_p[48:32];
        if (word.op == OP_CAPTURE)
        begin
            captured_reg <= capture;
            dither_reg   <= '0;
        end
        if (word.op == OP_LCG_B)
            dither_reg <= $signed({2'b0, lcg_a_reg}) + $signed({2'b0, lcg_new})
                        - 34'sh1_0000_0000;
        if (word.op == OP_SCALE)
            prod_reg <= mul_p[32:0];
        if (word.op == OP_ROUND)
            code_reg <= acc[49:32];
        if (word.op == OP_OUTPUT && out_free)
        begin
            crushed_reg    <= y_sat;
            level_code_reg <= code_reg;
            flag_reg       <= captured_reg;
        end
    end

    a_silence_bound: assert property (@(posedge clk) disable iff (!rst_n)
        silence_reg <= SIL_MAX)
        else $error("Silence counter passed its limit.");

    a_capture_clears_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (word.op == OP_CAPTURE && capture) |=> (phase_reg == 16'd0))
        else $error("Capture did not clear the phase counter.");

    a_single_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !s_tready)
        else $error("Second transfer taken before the item was processed.");

endmodule

[src/dithered_bit_crusher_top.sv]
// The microcode program steps one shared 34 x 22 multiplier through the LCG, jitter,
// scaling and reciprocal products, and skips the dither steps while the gate is off.
// A new sample is taken only once the previous one has reached the output register.
// A full output register holds the program at its last step until the result is taken.
// Reset clears the program counter, output valid and state and loads the register defaults.
module dithered_bit_crusher_top
    import dbc_pkg::*;
#(
    parameter int SILENCE_LIMIT = SILENCE_LIMIT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,  // [15:0] sample_in
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata,  // [15:0] crushed_sample, [33:16] level_code
    output logic                  m_tuser   // [0] captured
);

    ucode_t  word;
    status_t status;

    dbc_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .status   (status),
        .word     (word)
    );

    dbc_datapath #(
        .SILENCE_LIMIT (SILENCE_LIMIT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .word      (word),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

[tb/tb_dithered_bit_crusher_top.sv]
module tb_dithered_bit_crusher_top;
    import dbc_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] REG_NONE = 2'd3;
    localparam int CAP_ANY       = -1;
    localparam int DRAIN_CYCLES  = 16;
    localparam int RAND_PHASES   = 9;
    localparam int PHASE_ITEMS   = 125;
    localparam int SILENCE_RUN   = 530;
    localparam int SILENCE_LIMIT = SILENCE_LIMIT_DEF;

    typedef struct packed {
        logic [15:0] crushed;
        logic [17:0] code;
        logic        captured;
    } crush_t;

    typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_ADDR_W-1:0] addr;
        logic [15:0]           value;
        int                    cap;
    } dir_row_t;

    localparam dir_row_t DIR_ROWS [28] = '{
        '{ROW_SAMPLE, REG_NONE,        16'h0000, 1},
        '{ROW_SAMPLE, REG_NONE,        16'h7FFF, 1},
        '{ROW_SAMPLE, REG_NONE,        16'h8000, 1},
        '{ROW_SAMPLE, REG_NONE,        16'h0001, 1},
        '{ROW_SAMPLE, REG_NONE,        16'hFFFF, 1},
        '{ROW_CFG,    REG_BIT_DEPTH,   16'h0001, CAP_ANY},
        '{ROW_SAMPLE, REG_NONE,        16'h7FFF, 1},
        '{ROW_SAMPLE, REG_NONE,        16'h8000, 1},
        '{ROW_CFG,    REG_BIT_DEPTH,   16'h0010, CAP_ANY},
        '{ROW_SAMPLE, REG_NONE,        16'h7FFF, 1},
        '{ROW_SAMPLE, REG_NONE,        16'h8000, 1},
        '{ROW_CFG,    REG_BIT_DEPTH,   16'h0000, CAP_ANY},
        '{ROW_SAMPLE, REG_NONE,        16'h7FFF, 1},
        '{ROW_CFG,    REG_BIT_DEPTH,   16'h001F, CAP_ANY},
        '{ROW_SAMPLE, REG_NONE,        16'h8001, 1},
        '{ROW_CFG,    REG_BIT_DEPTH,   16'hFFE5, CAP_ANY},
        '{ROW_CFG,    REG_HOLD_PERIOD, 16'h0000, CAP_ANY},
        '{ROW_SAMPLE, REG_NONE,        16'h5555, 1},
        '{ROW_CFG,    REG_HOLD_PERIOD, 16'hFFFF, CAP_ANY},
        '{ROW_SAMPLE, REG_NONE,        16'hAAAA, 0},
        '{ROW_SAMPLE, REG_NONE,        16'h0064, 0},
        '{ROW_CFG,    REG_JITTER,      16'hFFFF, CAP_ANY},
        '{ROW_SAMPLE, REG_NONE,        16'h0007, 0},
        '{ROW_CFG,    REG_HOLD_PERIOD, 16'h0100, CAP_ANY},
        '{ROW_SAMPLE, REG_NONE,        16'h0BB8, CAP_ANY},
        '{ROW_SAMPLE, REG_NONE,        16'hF448, CAP_ANY},
        '{ROW_CFG,    REG_NONE,        16'hFFFF, CAP_ANY},
        '{ROW_SAMPLE, REG_NONE,        16'hFFFB, CAP_ANY}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [15:0]           s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [39:0]           m_tdata;
    logic                  m_tuser;

    logic [31:0]        lcg_a_m;
    logic [31:0]        lcg_b_m;
    int unsigned        silence_m;
    logic signed [15:0] held_m;
    int unsigned        phase_m;
    logic [4:0]         depth_r;
    logic [15:0]        hold_r;
    logic [15:0]        jitter_r;

    crush_t      crush_q [$];
    crush_t      want;
    int          send_idle;
    int          recv_idle;
    int unsigned fail_cnt = 0;

    dithered_bit_crusher_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] lcg_step(input logic [31:0] x);
        return x * LCG_MUL + LCG_ADD;
    endfunction

    function automatic crush_t crush_predict(input logic [15:0] smp);
        crush_t      r;
        int unsigned bd;
        longint      levels;
        longint      recip;
        longint      hp;
        longint      jt;
        longint      pc;
        longint      ua;
        longint      ub;
        longint      hv;
        longint      joff;
        longint      acc;
        longint      code;
        longint      y;
        bd = {27'b0, depth_r};
        if (bd < 1)
            bd = 1;
        if (bd > 16)
            bd = 16;
        levels = (longint'(1) << bd) - 1;
        recip  = ((longint'(1) << 32) + levels / 2) / levels;
        hp = longint'(hold_r);
        if (hp < 256)
            hp = 256;
        jt = longint'(jitter_r);

        if (phase_m < 65535)
            phase_m++;
        lcg_a_m = lcg_step(lcg_a_m);
        ua = longint'(lcg_a_m);
        joff = ((ua - (longint'(1) << 31)) * jt) >>> 32;
        pc = longint'(phase_m);
        r.captured = 1'b0;
        if (pc * 256 >= hp + joff)
        begin
            held_m     = $signed(smp);
            phase_m    = 0;
            r.captured = 1'b1;
        end

        if (held_m == 0)
        begin
            if (silence_m < SILENCE_LIMIT)
                silence_m++;
        end
        else
            silence_m = 0;

        hv  = longint'(held_m);
        acc = hv * levels * (longint'(1) << 17);
        if (silence_m < SILENCE_LIMIT)
        begin
            lcg_a_m = lcg_step(lcg_a_m);
            lcg_b_m = lcg_step(lcg_b_m);
            ua = longint'(lcg_a_m);
            ub = longint'(lcg_b_m);
            acc += ua + ub - (longint'(1) << 32);
        end
        acc += longint'(1) << 31;
        code = acc >>> 32;
        y = (code * recip + (longint'(1) << 16)) >>> 17;
        if (y > 32767)
            y = 32767;
        if (y < -32768)
            y = -32768;
        r.crushed = y[15:0];
        r.code    = code[17:0];
        return r;
    endfunction

    function automatic logic [15:0] rand_sample();
        int unsigned k;
        k = $urandom_range(0, 15);
        case (k)
            0, 1:    return 16'h0000;
            2:       return 16'h7FFF;
            3:       return 16'h8000;
            4:       return 16'($urandom_range(0, 16) - 8);
            5:       return $urandom_range(0, 1) ? 16'h8001 : 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_sample(input logic [15:0] smp, input int cap);
        crush_t p;
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        p = crush_predict(smp);
        if (cap != CAP_ANY)
            p.captured = cap[0];
        crush_q.push_back(p);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (crush_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (addr)
            REG_BIT_DEPTH:   depth_r  = data[4:0];
            REG_HOLD_PERIOD: hold_r   = data;
            REG_JITTER:      jitter_r = data;
            default:         ;
        endcase
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (crush_q.size() == 0)
            begin
                $error("result transfer with no expected result pending");
                fail_cnt++;
            end
            else
            begin
                want = crush_q.pop_front();
                if (m_tdata[15:0] !== want.crushed)
                begin
                    $error("crushed_sample: expected %0d, got %0d",
                           $signed(want.crushed), $signed(m_tdata[15:0]));
                    fail_cnt++;
                end
                if (m_tdata[33:16] !== want.code)
                begin
                    $error("level_code: expected %0d, got %0d",
                           $signed(want.code), $signed(m_tdata[33:16]));
                    fail_cnt++;
                end
                if (m_tuser !== want.captured)
                begin
                    $error("captured: expected %0d, got %0d", want.captured, m_tuser);
                    fail_cnt++;
                end
            end
        end
    end

    initial
    begin
        #5000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        dir_row_t    row;
        logic [15:0] depth_v;
        logic [15:0] hold_v;
        logic [15:0] jit_v;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        send_idle = 32;
        recv_idle = 47;
        lcg_a_m   = LCG_A_SEED;
        lcg_b_m   = LCG_B_SEED;
        silence_m = 0;
        held_m    = '0;
        phase_m   = 0;
        depth_r   = BIT_DEPTH_RST;
        hold_r    = HOLD_RST;
        jitter_r  = JITTER_RST;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 28; i++)
        begin
            row = DIR_ROWS[i];
            if (row.kind == ROW_CFG)
            begin
                settle();
                write_reg(row.addr, row.value);
            end
            else
                send_sample(row.value, row.cap);
        end

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            if (p == 3)
            begin
                send_idle = 47;
                recv_idle = 32;
            end
            if (p == 6)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            case (p)
                0:
                begin
                    depth_v = 16'd8;
                    hold_v  = 16'd256;
                    jit_v   = 16'd0;
                end
                1:
                begin
                    depth_v = 16'd1;
                    hold_v  = 16'd256;
                    jit_v   = 16'hFFFF;
                end
                2:
                begin
                    depth_v = 16'd16;
                    hold_v  = 16'hFFFF;
                    jit_v   = 16'd0;
                end
                3:
                begin
                    depth_v = 16'd0;
                    hold_v  = 16'd0;
                    jit_v   = 16'($urandom_range(0, 1023));
                end
                4:
                begin
                    depth_v = 16'd31;
                    hold_v  = 16'($urandom_range(256, 1024));
                    jit_v   = 16'($urandom_range(0, 65535));
                end
                default:
                begin
                    depth_v = 16'($urandom_range(0, 65535));
                    hold_v  = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                              : $urandom_range(0, 1536));
                    jit_v   = 16'($urandom_range(0, 1) ? $urandom_range(0, 65535)
                                                       : $urandom_range(0, 2048));
                end
            endcase
            settle();
            write_reg(REG_BIT_DEPTH, depth_v);
            write_reg(REG_HOLD_PERIOD, hold_v);
            write_reg(REG_JITTER, jit_v);
            // A long run of silence saturates the gate and switches the dither off.
            if (p == 0)
                repeat (SILENCE_RUN) send_sample(16'h0000, CAP_ANY);
            repeat (PHASE_ITEMS) send_sample(rand_sample(), CAP_ANY);
        end

        settle();
        if (fail_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[filelist.f]
src/dbc_pkg.sv
src/dbc_sequencer.sv
src/dbc_datapath.sv
src/dithered_bit_crusher_top.sv
tb/tb_dithered_bit_crusher_top.sv
